/* src/bmp_pkg.sv */
// Shared constants, states and lane control type for the bone matrix palette.
package bmp_pkg;

	localparam int DEF_MAX_BONES = 64;
	localparam int DEF_FRAC_BITS = 16;
	localparam int ELEM_W        = 32;
	localparam int ROW_W         = 4 * ELEM_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_MUL  = 6'b000100,
		S_ACC  = 6'b001000,
		S_FING = 6'b010000,
		S_FINO = 6'b100000
	} state_t;

	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic first;
	} lane_ctl_t;

endpackage

/* src/bmp_ram.sv */
// Generic simple dual-port RAM with registered read.
module bmp_ram #(
	parameter int W = 32,
	parameter int D = 4
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/bmp_lane.sv */
// One MAC lane: registered 32x32 product, 66-bit accumulator, floor shift and saturation.
module bmp_lane import bmp_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                     clk,
	input  lane_ctl_t                ctl,
	input  logic signed [ELEM_W-1:0] a,
	input  logic signed [ELEM_W-1:0] b,
	output logic signed [ELEM_W-1:0] res
);

	logic signed [63:0] prod_q;
	logic signed [65:0] acc_q;
	logic signed [65:0] sh;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= a * b;
		end
		if (ctl.acc_en) begin
			acc_q <= ctl.first ? 66'(prod_q) : acc_q + 66'(prod_q);
		end
	end

	// arithmetic shift is floor division by 2^FRAC_BITS
	assign sh = acc_q >>> FRAC_BITS;

	always_comb begin
		if (sh > 66'sd2147483647) begin
			res = 32'sh7fffffff;
		end else if (sh < -66'sd2147483648) begin
			res = 32'sh80000000;
		end else begin
			res = sh[31:0];
		end
	end

endmodule

/* src/bone_matrix_palette_core.sv */
// Top level of the bone matrix palette: input decode, sequencer, stores, lanes, output register.
//
// Input stream (s_*): one matrix row per word. tuser = kind (0 inverse bind
// row, 1 local transform row). Inverse bind rows and local rows 0..2 are
// absorbed in the cycle they are accepted. Row 3 of a local transform starts
// the sequencer: for each output row it runs eight MAC steps on four column
// lanes (four for global = parent * local, four for global * inverse bind),
// each step a store read, a multiply and an accumulate; after the first four it
// writes the global row, after the last four it hands the result row to the
// output register. s_tready is low while the sequencer runs.
// Output stream (m_*): four words per bone, tlast on row 3. If the receiver
// stalls, the sequencer holds before loading the next row until the output
// register is free. Reset clears the sequencer and the output valid; store
// contents stay undefined until written.
module bone_matrix_palette_core import bmp_pkg::*; #(
	parameter int MAX_BONES = DEF_MAX_BONES,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// bone[5:0], parent[12:6], row[14:13], elem_a[46:15], elem_b[78:47],
	// elem_c[110:79], elem_d[142:111], zero pad[143]
	input  logic [143:0] s_tdata,
	// kind[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_bone[5:0], out_row[7:6], out_a[39:8], out_b[71:40], out_c[103:72],
	// out_d[135:104]
	output logic [135:0] m_tdata,
	output logic         m_tlast
);

	localparam int AW = $clog2(MAX_BONES * 4);
	localparam logic signed [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;

	logic [5:0]       in_bone;
	logic [6:0]       in_parent;
	logic [1:0]       in_row;
	logic [ROW_W-1:0] in_elems;
	logic             acc_in;
	logic             bone_ok;

	assign in_bone   = s_tdata[5:0];
	assign in_parent = s_tdata[12:6];
	assign in_row    = s_tdata[14:13];
	assign in_elems  = s_tdata[142:15];
	assign acc_in    = s_tvalid && s_tready;
	assign bone_ok   = int'(in_bone) < MAX_BONES;

	state_t           state_q;
	logic [1:0]       i_q;
	logic [1:0]       k_q;
	logic             phq_q;
	logic             root_q;
	logic [5:0]       bone_q;
	logic [5:0]       par_q;
	logic [ROW_W-1:0] loc_q [4];
	logic [ROW_W-1:0] glob_q;
	logic             ov_q;
	logic [135:0]     od_q;
	logic             ol_q;

	logic [ROW_W-1:0] ib_rdata;
	logic [ROW_W-1:0] gl_rdata;
	logic [ROW_W-1:0] lane_row;
	logic             start;
	logic             emit;
	lane_ctl_t        ctl;
	logic signed [ELEM_W-1:0] lane_a;
	logic signed [ELEM_W-1:0] lane_b [4];
	logic signed [ELEM_W-1:0] lane_res [4];

	assign s_tready = state_q == S_IDLE;
	assign start    = acc_in && s_tuser && bone_ok && in_row == 2'd3;
	assign emit     = state_q == S_FINO && (!ov_q || m_tready);

	bmp_ram #(.W(ROW_W), .D(MAX_BONES * 4)) u_ib_ram (
		.clk   (clk),
		.we    (acc_in && !s_tuser && bone_ok),
		.waddr (AW'({4'b0, in_bone, in_row})),
		.wdata (in_elems),
		.raddr (AW'({4'b0, bone_q, k_q})),
		.rdata (ib_rdata)
	);

	bmp_ram #(.W(ROW_W), .D(MAX_BONES * 4)) u_gl_ram (
		.clk   (clk),
		.we    (state_q == S_FING),
		.waddr (AW'({4'b0, bone_q, i_q})),
		.wdata (lane_row),
		.raddr (AW'({4'b0, par_q, i_q})),
		.rdata (gl_rdata)
	);

	assign ctl.mul_en = state_q == S_MUL;
	assign ctl.acc_en = state_q == S_ACC;
	assign ctl.first  = k_q == 2'd0;

	// root bones go through the same path with an identity parent
	always_comb begin
		if (phq_q) begin
			lane_a = glob_q[ELEM_W*k_q +: ELEM_W];
		end else if (root_q) begin
			lane_a = (k_q == i_q) ? ONE : '0;
		end else begin
			lane_a = gl_rdata[ELEM_W*k_q +: ELEM_W];
		end
	end

	for (genvar j = 0; j < 4; j++) begin : g_lane
		assign lane_b[j] = phq_q ? ib_rdata[ELEM_W*j +: ELEM_W]
		                         : loc_q[k_q][ELEM_W*j +: ELEM_W];
		bmp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk (clk),
			.ctl (ctl),
			.a   (lane_a),
			.b   (lane_b[j]),
			.res (lane_res[j])
		);
		assign lane_row[ELEM_W*j +: ELEM_W] = lane_res[j];
	end

	always_ff @(posedge clk) begin
		if (acc_in && s_tuser && bone_ok) begin
			loc_q[in_row] <= in_elems;
		end
		if (start) begin
			bone_q <= in_bone;
			par_q  <= in_parent[5:0];
			root_q <= in_parent[6] || int'(in_parent[5:0]) >= MAX_BONES;
		end
		if (state_q == S_FING) begin
			glob_q <= lane_row;
		end
		if (emit) begin
			od_q <= {lane_row, i_q, bone_q};
			ol_q <= i_q == 2'd3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			k_q     <= '0;
			phq_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (emit) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						i_q     <= '0;
						k_q     <= '0;
						phq_q   <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD:  state_q <= S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= phq_q ? S_FINO : S_FING;
					end else begin
						state_q <= S_RD;
					end
				end
				S_FING: begin
					phq_q   <= 1'b1;
					state_q <= S_RD;
				end
				S_FINO: begin
					if (emit) begin
						phq_q <= 1'b0;
						i_q   <= i_q + 2'd1;
						state_q <= (i_q == 2'd3) ? S_IDLE : S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;
	assign m_tlast  = ol_q;

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[7:6] == 2'd3)
		else $error("tlast on a row other than 3");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !s_tready)
		else $error("input not stalled after local row 3");

	a_fing_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FING |-> !phq_q && k_q == 2'd0)
		else $error("global row written outside the parent phase");

endmodule

/* tb/bone_matrix_palette_core_chk.sv */
// Checker for the bone matrix palette: predicts final skinning rows and compares them.
module bone_matrix_palette_core_chk import bmp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [143:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [135:0] m_tdata,
	input  logic         m_tlast,
	output int           fail_count,
	output int           rows_pending
);

	localparam int NB = DEF_MAX_BONES;
	localparam int FB = DEF_FRAC_BITS;

	typedef logic signed [31:0] elem_t;
	typedef elem_t mat_t [16];

	typedef struct packed {
		logic [5:0]   bone;
		logic [1:0]   row;
		logic [127:0] elems;
		logic         last;
	} pal_row_t;

	mat_t inv_bind [NB];
	mat_t glob_mat [NB];
	mat_t local_buf;
	pal_row_t palette_q [$];

	function automatic longint floor_q(longint v);
		return v >>> FB;
	endfunction

	function automatic mat_t mat_product(mat_t a, mat_t b);
		mat_t d;
		longint p, hi, hs, ls, t;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				hs = 0;
				ls = 0;
				for (int k = 0; k < 4; k++) begin
					p = longint'(a[i*4+k]) * longint'(b[k*4+j]);
					hi = floor_q(p);
					hs += hi;
					ls += p - (hi <<< FB);
				end
				t = hs + floor_q(ls);
				if (t > 64'sd2147483647)
					d[i*4+j] = 32'sh7fffffff;
				else if (t < -64'sd2147483648)
					d[i*4+j] = 32'sh80000000;
				else
					d[i*4+j] = elem_t'(t);
			end
		return d;
	endfunction

	task automatic absorb_word(logic kind, logic [143:0] w);
		logic [5:0] bone;
		logic [6:0] par;
		logic [1:0] row;
		mat_t g, f;
		pal_row_t r;
		bone = w[5:0];
		par = w[12:6];
		row = w[14:13];
		if (bone >= NB)
			return;
		for (int i = 0; i < 4; i++) begin
			if (!kind)
				inv_bind[bone][row*4+i] = w[15+32*i +: 32];
			else
				local_buf[row*4+i] = w[15+32*i +: 32];
		end
		if (!kind || row != 3)
			return;
		if (par[6] || par >= NB)
			g = local_buf;
		else
			g = mat_product(glob_mat[par], local_buf);
		glob_mat[bone] = g;
		f = mat_product(g, inv_bind[bone]);
		for (int k = 0; k < 4; k++) begin
			r.bone = bone;
			r.row = 2'(k);
			r.elems = {f[k*4+3], f[k*4+2], f[k*4+1], f[k*4]};
			r.last = (k == 3);
			palette_q.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pal_row_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (palette_q.size() == 0) begin
					$error("unexpected word: %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					e = palette_q.pop_front();
					if (m_tdata[5:0] !== e.bone || m_tdata[7:6] !== e.row
							|| m_tdata[135:8] !== e.elems || m_tlast !== e.last) begin
						fail_count <= fail_count + 1;
						if (m_tdata[5:0] !== e.bone)
							$error("out_bone exp %0d got %0d", e.bone, m_tdata[5:0]);
						if (m_tdata[7:6] !== e.row)
							$error("out_row exp %0d got %0d", e.row, m_tdata[7:6]);
						for (int i = 0; i < 4; i++)
							if (m_tdata[8+32*i +: 32] !== e.elems[32*i +: 32])
								$error("out_%c exp %h got %h", 8'(97 + i),
									e.elems[32*i +: 32], m_tdata[8+32*i +: 32]);
						if (m_tlast !== e.last)
							$error("last exp %b got %b", e.last, m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready)
				absorb_word(s_tuser, s_tdata);
			rows_pending = palette_q.size();
		end
	end

endmodule

/* tb/bone_matrix_palette_core_tb.sv */
// Testbench top for the bone matrix palette: stimulus, idling and verdict.
module bone_matrix_palette_core_tb;

	localparam logic KIND_INV = 1'b0;
	localparam logic KIND_LOC = 1'b1;
	localparam logic [6:0] ROOT = 7'h7f;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [143:0] s_tdata = '0;
	logic         s_tuser = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [135:0] m_tdata;
	logic         m_tlast;
	int           fail_count;
	int           rows_pending;
	int           cycles = 0;
	bit           bound [64];
	bit           placed [64];

	always #4 clk = ~clk;

	bone_matrix_palette_core u_dut (.*);

	bone_matrix_palette_core_chk u_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("bone_matrix_palette_core: mismatch");
			$finish;
		end
	end

	// receiver stalls: per word, random gap then ready until taken
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
			3: return $urandom;
			default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
		endcase
	endfunction

	task automatic send_word(logic kind, logic [5:0] bone, logic [6:0] par, logic [1:0] row,
			logic [127:0] elems);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {1'b0, elems, row, par, bone};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (kind == KIND_INV && row == 3)
			bound[bone] = 1;
	endtask

	task automatic send_matrix(logic kind, logic [5:0] bone, logic [6:0] par, bit ident);
		logic [127:0] e;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++)
				e[32*c +: 32] = ident ? ((c == r) ? 32'h00010000 : 32'h0) : rand_elem();
			send_word(kind, bone, par, 2'(r), e);
		end
		if (kind == KIND_LOC)
			placed[bone] = 1;
	endtask

	// pick a parent among bones already placed, else root
	function automatic logic [6:0] pick_parent();
		int n;
		n = $urandom_range(0, 63);
		if ($urandom_range(0, 3) == 0 || !placed[n])
			return ($urandom_range(0, 1) ? ROOT : 7'h40 | 7'($urandom_range(0, 63)));
		return 7'(n);
	endfunction

	initial begin
		logic [5:0] b;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: identity, extremes, self parent, chain
		send_matrix(KIND_INV, 6'd0, ROOT, 1'b1);
		send_matrix(KIND_LOC, 6'd0, ROOT, 1'b0);
		send_matrix(KIND_INV, 6'd63, ROOT, 1'b0);
		send_word(KIND_LOC, 6'd63, 7'd63, 2'd0, {4{32'h7fffffff}});
		send_word(KIND_LOC, 6'd63, 7'd63, 2'd1, {4{32'h80000000}});
		send_word(KIND_LOC, 6'd63, 7'd63, 2'd2, {4{32'h7fffffff}});
		send_word(KIND_LOC, 6'd63, 7'd0, 2'd3, {4{32'h80000000}});
		placed[63] = 1;
		send_matrix(KIND_LOC, 6'd63, 7'd63, 1'b0);
		send_matrix(KIND_LOC, 6'd0, 7'd63, 1'b0);
		// random: mostly full bones with placed parents
		for (int n = 0; n < 57; n++) begin
			b = 6'($urandom_range(0, 63));
			if (!bound[b] || $urandom_range(0, 4) == 0)
				send_matrix(KIND_INV, b, ROOT, $urandom_range(0, 7) == 0);
			send_matrix(KIND_LOC, b, pick_parent(), 1'b0);
		end
		s_tvalid <= 0;
		while (rows_pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("bone_matrix_palette_core: match");
		else
			$display("bone_matrix_palette_core: mismatch");
		$finish;
	end

endmodule
